>>> design/ksle_pkg.sv
// ---------------------------------------------------------------------------
// ksle_pkg
// Shared types, codes and key tables for the scancode line editor.
// ---------------------------------------------------------------------------
package ksle_pkg;

    localparam int unsigned SCAN_W  = 8;
    localparam int unsigned CHAR_W  = 7;
    localparam int unsigned KIND_W  = 2;
    localparam int unsigned S_TDATA_W = 8;
    localparam int unsigned M_TDATA_W = 8;
    localparam int unsigned M_TUSER_W = 2;

    localparam logic [SCAN_W-1:0] SC_LSHIFT     = 8'h2A;
    localparam logic [SCAN_W-1:0] SC_RSHIFT     = 8'h36;
    localparam logic [SCAN_W-1:0] SC_LSHIFT_BRK = 8'hAA;
    localparam logic [SCAN_W-1:0] SC_RSHIFT_BRK = 8'hB6;
    localparam logic [SCAN_W-1:0] SC_CAPS       = 8'h3A;
    localparam logic [SCAN_W-1:0] SC_BACKSPACE  = 8'h0E;
    localparam logic [SCAN_W-1:0] SC_ENTER      = 8'h1C;

    localparam logic [CHAR_W-1:0] CH_NONE   = 7'h00;
    localparam logic [CHAR_W-1:0] CH_LOW_A  = 7'h61;
    localparam logic [CHAR_W-1:0] CH_LOW_Z  = 7'h7A;
    localparam logic [CHAR_W-1:0] CH_DIG_0  = 7'h30;
    localparam logic [CHAR_W-1:0] CH_DIG_9  = 7'h39;
    localparam logic [CHAR_W-1:0] CH_CASE   = 7'h20;

    typedef enum logic [KIND_W-1:0] {
        KIND_ECHO      = 2'd0,
        KIND_ERASE     = 2'd1,
        KIND_LINE_CHAR = 2'd2,
        KIND_LINE_END  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        CMD_ECHO,
        CMD_ERASE,
        CMD_ENTER
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t             op;
        logic [CHAR_W-1:0]   ch;
    } cmd_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DRAIN,
        BK_END
    } back_state_t;

    // keypad digits, independent of shift; zero when not a keypad digit
    function automatic logic [CHAR_W-1:0] keypad_digit(input logic [SCAN_W-1:0] sc);
        logic [CHAR_W-1:0] ch;
        case (sc)
            8'h47:   ch = 7'h37;
            8'h48:   ch = 7'h38;
            8'h49:   ch = 7'h39;
            8'h4B:   ch = 7'h34;
            8'h4C:   ch = 7'h35;
            8'h4D:   ch = 7'h36;
            8'h4F:   ch = 7'h31;
            8'h50:   ch = 7'h32;
            8'h51:   ch = 7'h33;
            8'h52:   ch = 7'h30;
            default: ch = CH_NONE;
        endcase
        return ch;
    endfunction

    // main map, unshifted: letters, digits and space only
    function automatic logic [CHAR_W-1:0] key_map(input logic [5:0] idx);
        logic [CHAR_W-1:0] ch;
        case (idx)
            6'h02: ch = 7'h31;
            6'h03: ch = 7'h32;
            6'h04: ch = 7'h33;
            6'h05: ch = 7'h34;
            6'h06: ch = 7'h35;
            6'h07: ch = 7'h36;
            6'h08: ch = 7'h37;
            6'h09: ch = 7'h38;
            6'h0A: ch = 7'h39;
            6'h0B: ch = 7'h30;
            6'h10: ch = 7'h71;
            6'h11: ch = 7'h77;
            6'h12: ch = 7'h65;
            6'h13: ch = 7'h72;
            6'h14: ch = 7'h74;
            6'h15: ch = 7'h79;
            6'h16: ch = 7'h75;
            6'h17: ch = 7'h69;
            6'h18: ch = 7'h6F;
            6'h19: ch = 7'h70;
            6'h1E: ch = 7'h61;
            6'h1F: ch = 7'h73;
            6'h20: ch = 7'h64;
            6'h21: ch = 7'h66;
            6'h22: ch = 7'h67;
            6'h23: ch = 7'h68;
            6'h24: ch = 7'h6A;
            6'h25: ch = 7'h6B;
            6'h26: ch = 7'h6C;
            6'h2C: ch = 7'h7A;
            6'h2D: ch = 7'h78;
            6'h2E: ch = 7'h63;
            6'h2F: ch = 7'h76;
            6'h30: ch = 7'h62;
            6'h31: ch = 7'h6E;
            6'h32: ch = 7'h6D;
            6'h39: ch = 7'h20;
            default: ch = CH_NONE;
        endcase
        return ch;
    endfunction

endpackage

>>> design/ksle_front.sv
// ---------------------------------------------------------------------------
// ksle_front
// Accepts scancodes, tracks shift and caps lock, issues editor commands.
// ---------------------------------------------------------------------------
module ksle_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [ksle_pkg::S_TDATA_W-1:0]    s_tdata,   // [7:0] scancode
    input  logic                              q_full,
    output logic                              q_push,
    output ksle_pkg::cmd_t                    q_cmd
);

    logic                              shift_reg, shift_next;
    logic                              caps_reg, caps_next;
    logic                              accept;
    logic [ksle_pkg::SCAN_W-1:0]       sc;
    logic [ksle_pkg::CHAR_W-1:0]       kp_ch;
    logic [ksle_pkg::CHAR_W-1:0]       map_ch;
    logic                              is_alpha;
    logic                              is_digit;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign sc       = s_tdata[ksle_pkg::SCAN_W-1:0];
    assign kp_ch    = ksle_pkg::keypad_digit(sc);
    assign map_ch   = (sc[7:6] == 2'b00) ? ksle_pkg::key_map(sc[5:0]) : ksle_pkg::CH_NONE;
    assign is_alpha = (map_ch >= ksle_pkg::CH_LOW_A) && (map_ch <= ksle_pkg::CH_LOW_Z);
    assign is_digit  = (map_ch >= ksle_pkg::CH_DIG_0) && (map_ch <= ksle_pkg::CH_DIG_9);

    always_comb begin
        shift_next = shift_reg;
        caps_next  = caps_reg;
        q_push     = 1'b0;
        q_cmd.op   = ksle_pkg::CMD_ECHO;
        q_cmd.ch   = ksle_pkg::CH_NONE;
        if (accept) begin
            if (sc[7]) begin
                if (sc == ksle_pkg::SC_LSHIFT_BRK || sc == ksle_pkg::SC_RSHIFT_BRK) begin
                    shift_next = 1'b0;
                end
            end else if (kp_ch != ksle_pkg::CH_NONE) begin
                q_push = 1'b1;
                q_cmd.ch = kp_ch;
            end else if (sc == ksle_pkg::SC_LSHIFT || sc == ksle_pkg::SC_RSHIFT) begin
                shift_next = 1'b1;
            end else if (sc == ksle_pkg::SC_CAPS) begin
                caps_next = !caps_reg;
            end else if (sc == ksle_pkg::SC_BACKSPACE) begin
                q_push   = 1'b1;
                q_cmd.op = ksle_pkg::CMD_ERASE;
            end else if (sc == ksle_pkg::SC_ENTER) begin
                q_push   = 1'b1;
                q_cmd.op = ksle_pkg::CMD_ENTER;
            end else if (is_alpha) begin
                q_push   = 1'b1;
                q_cmd.ch = (caps_reg || shift_reg) ? (map_ch - ksle_pkg::CH_CASE) : map_ch;
            end else if (is_digit) begin
                q_push   = !shift_reg;
                q_cmd.ch = map_ch;
            end else if (map_ch != ksle_pkg::CH_NONE) begin
                // space
                q_push   = 1'b1;
                q_cmd.ch = map_ch;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_reg <= 1'b0;
            caps_reg  <= 1'b0;
        end else begin
            shift_reg <= shift_next;
            caps_reg  <= caps_next;
        end
    end

endmodule

>>> design/ksle_queue.sv
// ---------------------------------------------------------------------------
// ksle_queue
// Two-entry command queue between front and back.
// ---------------------------------------------------------------------------
module ksle_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  ksle_pkg::cmd_t   push_cmd,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output ksle_pkg::cmd_t   head_cmd
);

    ksle_pkg::cmd_t  slot_reg [2];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      count_reg, count_next;
    logic            do_push, do_pop;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_cmd   = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 2'd1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> design/ksle_back.sv
// ---------------------------------------------------------------------------
// ksle_back
// Executes editor commands against the line memory and drives results.
// ---------------------------------------------------------------------------
module ksle_back #(
    parameter int unsigned BUFFER_DEPTH = 64
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              q_valid,
    input  ksle_pkg::cmd_t                    q_cmd,
    output logic                              q_pop,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [ksle_pkg::M_TDATA_W-1:0]    m_tdata,   // [6:0] char_code
    output logic [ksle_pkg::M_TUSER_W-1:0]    m_tuser,   // [1:0] kind
    output logic                              m_tlast
);

    localparam int unsigned AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam logic [AW-1:0] FILL_MAX = AW'(BUFFER_DEPTH - 1);

    logic [ksle_pkg::CHAR_W-1:0]  line_mem [BUFFER_DEPTH];

    ksle_pkg::back_state_t        state_reg, state_next;
    logic [AW-1:0]                fill_reg, fill_next;
    logic [AW-1:0]                idx_reg, idx_next;
    logic [AW-1:0]                idx_inc;
    logic [ksle_pkg::CHAR_W-1:0]  rd_data_reg;
    logic                         out_valid_reg, out_valid_next;
    ksle_pkg::kind_t              out_kind_reg;
    logic [ksle_pkg::CHAR_W-1:0]  out_char_reg;
    logic                         out_last_reg;

    logic                         out_free;
    logic                         load;
    ksle_pkg::kind_t              load_kind;
    logic [ksle_pkg::CHAR_W-1:0]  load_char;
    logic                         load_last;
    logic                         wr_en;
    logic                         rd_en;
    logic [AW-1:0]                rd_idx;
    logic                         drain_done;

    assign out_free   = !out_valid_reg || m_tready;
    assign idx_inc    = idx_reg + 1'b1;
    assign drain_done = (idx_inc == fill_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ksle_pkg::BK_IDLE: begin
                if (q_valid && out_free && q_cmd.op == ksle_pkg::CMD_ENTER &&
                    fill_reg != '0) begin
                    state_next = ksle_pkg::BK_DRAIN;
                end
            end
            ksle_pkg::BK_DRAIN: begin
                if (out_free && drain_done) begin
                    state_next = ksle_pkg::BK_END;
                end
            end
            ksle_pkg::BK_END: begin
                if (out_free) begin
                    state_next = ksle_pkg::BK_IDLE;
                end
            end
            default: state_next = ksle_pkg::BK_IDLE;
        endcase
    end

    // datapath controls
    always_comb begin
        q_pop     = 1'b0;
        load      = 1'b0;
        load_kind = ksle_pkg::KIND_ECHO;
        load_char = ksle_pkg::CH_NONE;
        load_last = 1'b1;
        wr_en     = 1'b0;
        rd_en     = 1'b0;
        rd_idx    = '0;
        fill_next = fill_reg;
        idx_next  = idx_reg;
        case (state_reg)
            ksle_pkg::BK_IDLE: begin
                if (q_valid && out_free) begin
                    q_pop = 1'b1;
                    load  = 1'b1;
                    case (q_cmd.op)
                        ksle_pkg::CMD_ECHO: begin
                            load_char = q_cmd.ch;
                            if (fill_reg < FILL_MAX) begin
                                wr_en     = 1'b1;
                                fill_next = fill_reg + 1'b1;
                            end
                        end
                        ksle_pkg::CMD_ERASE: begin
                            load_kind = ksle_pkg::KIND_ERASE;
                            if (fill_reg != '0) begin
                                fill_next = fill_reg - 1'b1;
                            end
                        end
                        ksle_pkg::CMD_ENTER: begin
                            if (fill_reg == '0) begin
                                load_kind = ksle_pkg::KIND_LINE_END;
                            end else begin
                                load     = 1'b0;
                                rd_en    = 1'b1;
                                idx_next = '0;
                            end
                        end
                        default: load = 1'b0;
                    endcase
                end
            end
            ksle_pkg::BK_DRAIN: begin
                if (out_free) begin
                    load      = 1'b1;
                    load_kind = ksle_pkg::KIND_LINE_CHAR;
                    load_char = rd_data_reg;
                    load_last = 1'b0;
                    if (!drain_done) begin
                        rd_en    = 1'b1;
                        rd_idx   = idx_inc;
                        idx_next = idx_inc;
                    end
                end
            end
            ksle_pkg::BK_END: begin
                if (out_free) begin
                    load      = 1'b1;
                    load_kind = ksle_pkg::KIND_LINE_END;
                    fill_next = '0;
                end
            end
            default: ;
        endcase
    end

    assign out_valid_next = load ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ksle_pkg::BK_IDLE;
            fill_reg      <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_kind_reg <= load_kind;
            out_char_reg <= load_char;
            out_last_reg <= load_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            line_mem[fill_reg] <= q_cmd.ch;
        end
        if (rd_en) begin
            rd_data_reg <= line_mem[rd_idx];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {{(ksle_pkg::M_TDATA_W - ksle_pkg::CHAR_W){1'b0}}, out_char_reg};

endmodule

>>> design/keyboard_scancode_line_editor.sv
// ---------------------------------------------------------------------------
// keyboard_scancode_line_editor
// Set-1 scancode to ASCII line editor with echo, erase and line output.
// ---------------------------------------------------------------------------
// Output: each result is registered before it appears on m_*.
// Throughput: one scancode per cycle while the 2-entry queue has room; the back
//   end gives one result per echo, erase or empty-line enter, and for an enter
//   on a nonempty line a read, then each line character in order, then a line end.
// Reset: aresetn low clears shift, caps lock, line fill, queue and output valid.
module keyboard_scancode_line_editor #(
    parameter int unsigned BUFFER_DEPTH = 64
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [ksle_pkg::S_TDATA_W-1:0]    s_tdata,   // [7:0] scancode
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [ksle_pkg::M_TDATA_W-1:0]    m_tdata,   // [6:0] char_code
    output logic [ksle_pkg::M_TUSER_W-1:0]    m_tuser,   // [1:0] kind
    output logic                              m_tlast
);

    logic             q_full;
    logic             q_push;
    ksle_pkg::cmd_t   q_push_cmd;
    logic             q_pop;
    logic             q_valid;
    ksle_pkg::cmd_t   q_head;

    ksle_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (q_push_cmd)
    );

    ksle_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_cmd   (q_push_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_cmd   (q_head)
    );

    ksle_back #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_cmd    (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

>>> design/ksle_checker.sv
// ---------------------------------------------------------------------------
// ksle_checker
// Port-level checks for the scancode line editor, bound to the top level.
// ---------------------------------------------------------------------------
module ksle_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tready,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [ksle_pkg::M_TDATA_W-1:0]    m_tdata,
    input  logic [ksle_pkg::M_TUSER_W-1:0]    m_tuser,
    input  logic                              m_tlast
);

    logic [ksle_pkg::KIND_W-1:0]  kind;
    logic [ksle_pkg::CHAR_W-1:0]  char_code;

    assign kind      = m_tuser[ksle_pkg::KIND_W-1:0];
    assign char_code = m_tdata[ksle_pkg::CHAR_W-1:0];

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
                                  $stable(m_tlast))
        else $error("result changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("result valid or input blocked right after reset");

    a_last_by_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (kind != ksle_pkg::KIND_LINE_CHAR)))
        else $error("tlast does not match result kind");

    a_no_char: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (kind == ksle_pkg::KIND_ERASE || kind == ksle_pkg::KIND_LINE_END)
        |-> char_code == ksle_pkg::CH_NONE)
        else $error("erase or line end carries a character");

    a_line_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && kind == ksle_pkg::KIND_LINE_CHAR
        |=> m_tvalid && (kind == ksle_pkg::KIND_LINE_CHAR ||
                         kind == ksle_pkg::KIND_LINE_END))
        else $error("line output interrupted");

endmodule

bind keyboard_scancode_line_editor ksle_checker u_ksle_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

>>> tb/sv/tb_keyboard_scancode_line_editor.sv
// ---------------------------------------------------------------------------
// tb_keyboard_scancode_line_editor
// Self-checking bench for the set-1 scancode line editor. Scancodes go in on
// the s_ stream, a local model of shift, caps lock and the line store
// predicts the echo, erase and line transfers, and every m_ transfer is
// compared in order. Covers modifiers, break codes, keypad keys, edit keys,
// line overflow, long output back-pressure and random typing sessions.
// ---------------------------------------------------------------------------
module tb_keyboard_scancode_line_editor;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_DEPTH  = 64;
    localparam int STALL_LIMIT = 5000;
    localparam int TOTAL_ITEMS = 370;

    typedef struct packed {
        ksle_pkg::kind_t             kind;
        logic [ksle_pkg::CHAR_W-1:0] ch;
        logic                        last;
    } editor_result_t;

    logic                           aclk     = 1'b0;
    logic                           aresetn  = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [ksle_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [ksle_pkg::M_TDATA_W-1:0] m_tdata;
    logic [ksle_pkg::M_TUSER_W-1:0] m_tuser;
    logic                           m_tlast;

    editor_result_t              pending_results[$];
    logic [ksle_pkg::CHAR_W-1:0] main_keys[0:63];
    logic [ksle_pkg::SCAN_W-1:0] char_scancodes[$];
    logic [ksle_pkg::CHAR_W-1:0] line_chars[0:LINE_DEPTH-1];
    logic [6:0]        line_len    = '0;
    logic              shift_held  = 1'b0;
    logic              caps_active = 1'b0;
    int                sent_items  = 0;
    int                mismatch_count = 0;
    int                stall_cycles = 0;
    int                hold_cycles  = 0;
    bit                no_idle      = 1'b0;

    keyboard_scancode_line_editor #(
        .BUFFER_DEPTH(LINE_DEPTH)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic void push_result(ksle_pkg::kind_t kind,
                                        logic [ksle_pkg::CHAR_W-1:0] ch, logic last);
        editor_result_t r;
        r.kind = kind;
        r.ch   = ch;
        r.last = last;
        pending_results.push_back(r);
    endfunction

    // updates the editor state and queues the transfers one scancode causes
    function automatic int predict_keystroke(input logic [ksle_pkg::SCAN_W-1:0] sc);
        localparam logic [8*13-1:0] KEYPAD_ROW = "789-456+1230.";
        logic [ksle_pkg::CHAR_W-1:0] ch;
        logic              printable;
        ch = ksle_pkg::CH_NONE;
        if (sc[7]) begin
            if (sc == ksle_pkg::SC_LSHIFT_BRK || sc == ksle_pkg::SC_RSHIFT_BRK)
                shift_held = 1'b0;
            return 0;
        end
        if (sc >= 8'h47 && sc <= 8'h53)
            ch = KEYPAD_ROW[8*(12 - (sc - 8'h47)) +: 7];
        if (ch == ksle_pkg::CH_NONE) begin
            if (sc == ksle_pkg::SC_LSHIFT || sc == ksle_pkg::SC_RSHIFT) begin
                shift_held = 1'b1;
                return 0;
            end
            if (sc == ksle_pkg::SC_CAPS) begin
                caps_active = !caps_active;
                return 0;
            end
            if (sc == ksle_pkg::SC_BACKSPACE) begin
                if (line_len > 0)
                    line_len--;
                push_result(ksle_pkg::KIND_ERASE, ksle_pkg::CH_NONE, 1'b1);
                return 1;
            end
            if (sc == ksle_pkg::SC_ENTER) begin
                for (int i = 0; i < line_len; i++)
                    push_result(ksle_pkg::KIND_LINE_CHAR, line_chars[i], 1'b0);
                push_result(ksle_pkg::KIND_LINE_END, ksle_pkg::CH_NONE, 1'b1);
                ch = ksle_pkg::CH_NONE;
                line_len = '0;
                return 1;
            end
            if (sc < 64)
                ch = main_keys[sc[5:0]];
            if (ch >= ksle_pkg::CH_LOW_A && ch <= ksle_pkg::CH_LOW_Z) begin
                if (caps_active || shift_held)
                    ch = ch - ksle_pkg::CH_CASE;
            end else if (ch >= ksle_pkg::CH_DIG_0 && ch <= ksle_pkg::CH_DIG_9 &&
                         shift_held) begin
                ch = ksle_pkg::CH_NONE;
            end
        end
        printable = (ch >= ksle_pkg::CH_LOW_A && ch <= ksle_pkg::CH_LOW_Z) ||
                    (ch >= ksle_pkg::CH_LOW_A - ksle_pkg::CH_CASE &&
                     ch <= ksle_pkg::CH_LOW_Z - ksle_pkg::CH_CASE) ||
                    (ch >= ksle_pkg::CH_DIG_0 && ch <= ksle_pkg::CH_DIG_9) ||
                    ch == ksle_pkg::CH_CASE;
        if (!printable)
            return 0;
        push_result(ksle_pkg::KIND_ECHO, ch, 1'b1);
        if (line_len < LINE_DEPTH - 1) begin
            line_chars[line_len[5:0]] = ch;
            line_len++;
        end
        return 1;
    endfunction

    task automatic send_scancode(input logic [ksle_pkg::SCAN_W-1:0] sc);
        int unused;
        while (!no_idle && $urandom_range(0, 99) < 16) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        unused = predict_keystroke(sc);
        s_tvalid <= 1'b1;
        s_tdata  <= sc;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        sent_items++;
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
    endtask

    task automatic send_random_char();
        if ($urandom_range(0, 9) == 0)
            send_scancode(8'($urandom_range(8'h47, 8'h53)));
        else
            send_scancode(char_scancodes[$urandom_range(0, char_scancodes.size() - 1)]);
    endtask

    task automatic test_modifiers_and_breaks();
        send_scancode(8'h00);
        send_scancode(8'hFF);
        send_scancode(8'h80);
        send_scancode(ksle_pkg::SC_LSHIFT);
        send_scancode(8'h02);         // shifted digit, no transfer
        send_scancode(8'h1E);
        send_scancode(ksle_pkg::SC_LSHIFT_BRK);
        send_scancode(8'h1E);
        send_scancode(ksle_pkg::SC_RSHIFT);
        send_scancode(8'h39);
        send_scancode(ksle_pkg::SC_RSHIFT_BRK);
        send_scancode(ksle_pkg::SC_CAPS);
        send_scancode(8'h10);
        send_scancode(ksle_pkg::SC_LSHIFT);
        send_scancode(8'h2C);         // caps and shift both held
        send_scancode(ksle_pkg::SC_LSHIFT_BRK);
        send_scancode(ksle_pkg::SC_CAPS);
        wait_drain();
    endtask

    task automatic test_keypad();
        send_scancode(ksle_pkg::SC_LSHIFT);
        send_scancode(8'h47);
        send_scancode(8'h4A);
        send_scancode(8'h4E);
        send_scancode(8'h53);
        send_scancode(8'h52);
        send_scancode(ksle_pkg::SC_LSHIFT_BRK);
        send_scancode(8'h7F);
        wait_drain();
    endtask

    task automatic test_edit_keys();
        send_scancode(ksle_pkg::SC_BACKSPACE);
        send_scancode(ksle_pkg::SC_ENTER);
        send_scancode(ksle_pkg::SC_BACKSPACE);
        send_scancode(ksle_pkg::SC_ENTER);      // empty line
        send_scancode(ksle_pkg::SC_BACKSPACE);  // erase on empty line
        wait_drain();
    endtask

    // receiver holds off at first, then a line past capacity is typed and flushed
    task automatic test_overflow_backpressure();
        hold_cycles <= 300;
        repeat (LINE_DEPTH + 3)
            send_random_char();
        send_scancode(ksle_pkg::SC_BACKSPACE);
        send_scancode(8'h39);
        send_scancode(8'h0B);
        send_scancode(ksle_pkg::SC_ENTER);
        wait_drain();
    endtask

    task automatic type_random_line(input int len);
        int unsigned pick;
        for (int i = 0; i < len; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 4)
                send_scancode(ksle_pkg::SC_CAPS);
            else if (pick < 9)
                send_scancode($urandom_range(0, 1) ? ksle_pkg::SC_LSHIFT :
                                                     ksle_pkg::SC_RSHIFT);
            else if (pick < 15)
                send_scancode($urandom_range(0, 1) ? ksle_pkg::SC_LSHIFT_BRK :
                                                     ksle_pkg::SC_RSHIFT_BRK);
            else if (pick < 21)
                send_scancode(ksle_pkg::SC_BACKSPACE);
            else if (pick < 26)
                send_scancode(8'($urandom_range(0, 255)));
            else
                send_random_char();
        end
        send_scancode(ksle_pkg::SC_ENTER);
    endtask

    task automatic test_random_sessions();
        int lines;
        int len;
        lines = 0;
        while (sent_items < TOTAL_ITEMS) begin
            no_idle = (lines >= 3 && lines < 10);
            if ($urandom_range(0, 7) == 0)
                len = $urandom_range(60, 75);
            else
                len = $urandom_range(0, 14);
            if (len > TOTAL_ITEMS - sent_items - 1)
                len = TOTAL_ITEMS - sent_items - 1;
            type_random_line(len);
            lines++;
        end
        no_idle = 1'b0;
        wait_drain();
    endtask

    always @(posedge aclk) begin
        if (hold_cycles > 0) begin
            m_tready    <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            m_tready <= no_idle || $urandom_range(0, 99) >= 16;
        end
    end

    always @(posedge aclk) begin
        editor_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected transfer kind=%0d char=%h last=%b",
                         $time, m_tuser, m_tdata[6:0], m_tlast);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_tuser !== want.kind || m_tdata[6:0] !== want.ch ||
                    m_tlast !== want.last || m_tdata[7] !== 1'b0) begin
                    $display({"%0t: expected kind=%0d char=%h last=%b, ",
                              "got kind=%0d char=%h last=%b pad=%b"},
                             $time, want.kind, want.ch, want.last,
                             m_tuser, m_tdata[6:0], m_tlast, m_tdata[7]);
                    mismatch_count++;
                end
            end
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        localparam logic [8*10-1:0] TOP_ROW    = "1234567890";
        localparam logic [8*10-1:0] UPPER_ROW  = "qwertyuiop";
        localparam logic [8*9-1:0]  HOME_ROW   = "asdfghjkl";
        localparam logic [8*7-1:0]  BOTTOM_ROW = "zxcvbnm";
        for (int i = 0; i < 64; i++)
            main_keys[i] = ksle_pkg::CH_NONE;
        for (int i = 0; i < 10; i++) begin
            main_keys[8'h02 + i] = TOP_ROW[8*(9 - i) +: 7];
            main_keys[8'h10 + i] = UPPER_ROW[8*(9 - i) +: 7];
        end
        for (int i = 0; i < 9; i++)
            main_keys[8'h1E + i] = HOME_ROW[8*(8 - i) +: 7];
        for (int i = 0; i < 7; i++)
            main_keys[8'h2C + i] = BOTTOM_ROW[8*(6 - i) +: 7];
        main_keys[8'h39] = ksle_pkg::CH_CASE;
        for (int i = 0; i < 64; i++)
            if (main_keys[i] != ksle_pkg::CH_NONE)
                char_scancodes.push_back(8'(i));

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_modifiers_and_breaks();
        test_keypad();
        test_edit_keys();
        test_overflow_backpressure();
        test_random_sessions();

        repeat (20) @(posedge aclk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
